// ----- rtl/core/qwl_pkg.sv -----
// Shared types and codes of the quoted word line lexer.
`timescale 1ns / 1ps

package qwl_pkg;

    typedef enum logic [2:0] {
        MODE_BETWEEN = 3'd0,
        MODE_WORD    = 3'd1,
        MODE_SEMI    = 3'd2,
        MODE_QUOTE   = 3'd3,
        MODE_ESC     = 3'd4,
        MODE_HEX2    = 3'd5,
        MODE_DISCARD = 3'd6
    } lex_mode_t;

    localparam logic [1:0] EV_BEGIN = 2'd0;
    localparam logic [1:0] EV_CHAR  = 2'd1;
    localparam logic [1:0] EV_END   = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_BAD   = 2'd2;

    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_NEWLINE   = 8'h0a;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_QUOTE     = 8'h27;
    localparam logic [7:0] CH_SEMI      = 8'h3b;
    localparam logic [7:0] CH_BACKSLASH = 8'h5c;
    localparam logic [7:0] CH_UNDERLINE = 8'h5f;
    localparam logic [7:0] CH_LOWER_N   = 8'h6e;
    localparam logic [7:0] CH_LOWER_T   = 8'h74;
    localparam logic [7:0] CH_DELETE    = 8'h7f;

    typedef struct packed {
        logic [1:0] event_res;
        logic [7:0] char_value;
        logic [1:0] line_status;
        logic       continued;
        logic       last;
    } result_t;

endpackage

// ----- rtl/core/qwl_byte_if.sv -----
// Input channel carrying one raw byte per beat.
`timescale 1ns / 1ps

interface qwl_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

// ----- rtl/core/qwl_event_if.sv -----
// Output channel carrying one lexer event per beat.
`timescale 1ns / 1ps

interface qwl_event_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_res;
    logic [7:0] char_value;
    logic [1:0] line_status;
    logic       continued;
    logic       last;

    modport source (output valid, output event_res, output char_value, output line_status,
                    output continued, output last, input ready);
    modport sink (input valid, input event_res, input char_value, input line_status,
                  input continued, input last, output ready);
endinterface

// ----- rtl/core/quoted_word_line_lexer_core.sv -----
// Quoted word line lexer: splits a byte stream into word, character and line-end events.
`timescale 1ns / 1ps

// The lexer takes one byte per cycle while its output register is free and its holding
// register empty, and decodes it in a single pass into at most two events, which go to an
// output register. A byte that causes two events, such as the first character of a word or
// a byte following a lone hex escape digit, parks its second event in the holding register,
// and the input is held off until that event has moved into the output register. The output
// register lets a new byte be taken in the same cycle as the previous event is delivered.
module quoted_word_line_lexer_core (
    input  logic                clk,
    input  logic                rst_n,
    qwl_byte_if.sink            bytes,
    qwl_event_if.source         tokens
);

    qwl_pkg::lex_mode_t mode_reg;
    qwl_pkg::lex_mode_t mode_next;
    logic [3:0]         hex_reg;
    logic [3:0]         hex_next;
    logic               has_word_reg;
    logic               has_word_next;

    qwl_pkg::result_t   out_reg;
    logic               out_valid_reg;
    qwl_pkg::result_t   hold_reg;
    logic               hold_valid_reg;

    qwl_pkg::result_t   res0;
    qwl_pkg::result_t   res1;
    logic [1:0]         res_count;

    logic [7:0]         b;
    logic               accept;
    logic               out_free;

    logic               hex_ok;
    logic [3:0]         hex_val;

    logic               q_emit;
    logic               q_end;
    qwl_pkg::lex_mode_t q_mode;

    assign b        = bytes.in_byte;
    assign out_free = !out_valid_reg || tokens.ready;
    assign bytes.ready = out_free && !hold_valid_reg;
    assign accept   = bytes.valid && bytes.ready;

    always_comb
    begin
        hex_ok  = 1'b0;
        hex_val = 4'd0;
        if (b inside {[8'h30:8'h39]})
        begin
            hex_ok  = 1'b1;
            hex_val = b[3:0];
        end
        else if (b inside {[8'h61:8'h66]})
        begin
            hex_ok  = 1'b1;
            hex_val = b[3:0] + 4'd9;
        end
    end

    // Handling of a byte inside a quoted span.
    always_comb
    begin
        q_emit = 1'b0;
        q_end  = 1'b0;
        q_mode = qwl_pkg::MODE_QUOTE;
        if (b == qwl_pkg::CH_NEWLINE)
        begin
            q_end  = 1'b1;
            q_mode = qwl_pkg::MODE_BETWEEN;
        end
        else if (b < qwl_pkg::CH_SPACE || b >= qwl_pkg::CH_DELETE)
        begin
            q_mode = qwl_pkg::MODE_DISCARD;
        end
        else if (b == qwl_pkg::CH_QUOTE)
        begin
            q_mode = qwl_pkg::MODE_WORD;
        end
        else if (b == qwl_pkg::CH_BACKSLASH)
        begin
            q_mode = qwl_pkg::MODE_ESC;
        end
        else
        begin
            q_emit = 1'b1;
        end
    end

    always_comb
    begin
        mode_next     = mode_reg;
        hex_next      = hex_reg;
        has_word_next = has_word_reg;
        res0          = '0;
        res1          = '0;
        res_count     = 2'd0;

        case (mode_reg)
            qwl_pkg::MODE_SEMI:
            begin
                if (b == qwl_pkg::CH_NEWLINE)
                begin
                    res0.event_res   = qwl_pkg::EV_END;
                    res0.line_status = has_word_reg ? qwl_pkg::ST_OK : qwl_pkg::ST_EMPTY;
                    res0.continued   = 1'b1;
                    res_count        = 2'd1;
                    mode_next        = qwl_pkg::MODE_BETWEEN;
                    hex_next         = 4'd0;
                    has_word_next    = 1'b0;
                end
                else
                begin
                    mode_next = qwl_pkg::MODE_DISCARD;
                end
            end
            qwl_pkg::MODE_QUOTE:
            begin
                mode_next = q_mode;
                if (q_end)
                begin
                    res0.event_res   = qwl_pkg::EV_END;
                    res0.line_status = qwl_pkg::ST_BAD;
                    res_count        = 2'd1;
                    hex_next         = 4'd0;
                    has_word_next    = 1'b0;
                end
                else if (q_emit)
                begin
                    res0.event_res  = qwl_pkg::EV_CHAR;
                    res0.char_value = b;
                    res_count       = 2'd1;
                end
            end
            qwl_pkg::MODE_ESC:
            begin
                if (b == qwl_pkg::CH_BACKSLASH || b == qwl_pkg::CH_QUOTE ||
                    b == qwl_pkg::CH_LOWER_N || b == qwl_pkg::CH_LOWER_T ||
                    b == qwl_pkg::CH_UNDERLINE)
                begin
                    res0.event_res = qwl_pkg::EV_CHAR;
                    case (b)
                        qwl_pkg::CH_LOWER_N:   res0.char_value = qwl_pkg::CH_NEWLINE;
                        qwl_pkg::CH_LOWER_T:   res0.char_value = qwl_pkg::CH_TAB;
                        qwl_pkg::CH_UNDERLINE: res0.char_value = qwl_pkg::CH_SPACE;
                        default:               res0.char_value = b;
                    endcase
                    res_count = 2'd1;
                    mode_next = qwl_pkg::MODE_QUOTE;
                end
                else if (hex_ok)
                begin
                    hex_next  = hex_val;
                    mode_next = qwl_pkg::MODE_HEX2;
                end
                else if (b == qwl_pkg::CH_NEWLINE)
                begin
                    res0.event_res   = qwl_pkg::EV_END;
                    res0.line_status = qwl_pkg::ST_BAD;
                    res_count        = 2'd1;
                    mode_next        = qwl_pkg::MODE_BETWEEN;
                    hex_next         = 4'd0;
                    has_word_next    = 1'b0;
                end
                else
                begin
                    mode_next = qwl_pkg::MODE_DISCARD;
                end
            end
            qwl_pkg::MODE_HEX2:
            begin
                res0.event_res = qwl_pkg::EV_CHAR;
                res_count      = 2'd1;
                hex_next       = 4'd0;
                if (hex_ok)
                begin
                    res0.char_value = {hex_reg, hex_val};
                    mode_next       = qwl_pkg::MODE_QUOTE;
                end
                else
                begin
                    res0.char_value = {4'd0, hex_reg};
                    mode_next       = q_mode;
                    if (q_end)
                    begin
                        res1.event_res   = qwl_pkg::EV_END;
                        res1.line_status = qwl_pkg::ST_BAD;
                        res_count        = 2'd2;
                        has_word_next    = 1'b0;
                    end
                    else if (q_emit)
                    begin
                        res1.event_res  = qwl_pkg::EV_CHAR;
                        res1.char_value = b;
                        res_count       = 2'd2;
                    end
                end
            end
            qwl_pkg::MODE_DISCARD:
            begin
                if (b == qwl_pkg::CH_NEWLINE)
                begin
                    res0.event_res   = qwl_pkg::EV_END;
                    res0.line_status = qwl_pkg::ST_BAD;
                    res_count        = 2'd1;
                    mode_next        = qwl_pkg::MODE_BETWEEN;
                    hex_next         = 4'd0;
                    has_word_next    = 1'b0;
                end
            end
            default:
            begin
                if (b == qwl_pkg::CH_SPACE || b == qwl_pkg::CH_TAB)
                begin
                    mode_next = qwl_pkg::MODE_BETWEEN;
                end
                else if (b == qwl_pkg::CH_NEWLINE)
                begin
                    res0.event_res   = qwl_pkg::EV_END;
                    res0.line_status = has_word_reg ? qwl_pkg::ST_OK : qwl_pkg::ST_EMPTY;
                    res_count        = 2'd1;
                    mode_next        = qwl_pkg::MODE_BETWEEN;
                    hex_next         = 4'd0;
                    has_word_next    = 1'b0;
                end
                else if (b == qwl_pkg::CH_SEMI)
                begin
                    mode_next = (mode_reg == qwl_pkg::MODE_WORD) ? qwl_pkg::MODE_DISCARD
                                                                 : qwl_pkg::MODE_SEMI;
                end
                else if (b <= qwl_pkg::CH_SPACE || b >= qwl_pkg::CH_DELETE)
                begin
                    mode_next = qwl_pkg::MODE_DISCARD;
                end
                else if (mode_reg != qwl_pkg::MODE_WORD)
                begin
                    res0.event_res = qwl_pkg::EV_BEGIN;
                    has_word_next  = 1'b1;
                    if (b == qwl_pkg::CH_QUOTE)
                    begin
                        res_count = 2'd1;
                        mode_next = qwl_pkg::MODE_QUOTE;
                    end
                    else
                    begin
                        res1.event_res  = qwl_pkg::EV_CHAR;
                        res1.char_value = b;
                        res_count       = 2'd2;
                        mode_next       = qwl_pkg::MODE_WORD;
                    end
                end
                else if (b == qwl_pkg::CH_QUOTE)
                begin
                    mode_next = qwl_pkg::MODE_QUOTE;
                end
                else
                begin
                    res0.event_res  = qwl_pkg::EV_CHAR;
                    res0.char_value = b;
                    res_count       = 2'd1;
                end
            end
        endcase

        if (res_count == 2'd2)
        begin
            res1.last = 1'b1;
        end
        else
        begin
            res0.last = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= qwl_pkg::MODE_BETWEEN;
            hex_reg      <= 4'd0;
            has_word_reg <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg     <= mode_next;
            hex_reg      <= hex_next;
            has_word_reg <= has_word_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
        end
        else if (hold_valid_reg && out_free)
        begin
            out_valid_reg  <= 1'b1;
            hold_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg  <= (res_count != 2'd0);
            hold_valid_reg <= (res_count == 2'd2);
        end
        else if (tokens.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hold_valid_reg && out_free)
        begin
            out_reg <= hold_reg;
        end
        else if (accept)
        begin
            out_reg  <= res0;
            hold_reg <= res1;
        end
    end

    assign tokens.valid       = out_valid_reg;
    assign tokens.event_res   = out_reg.event_res;
    assign tokens.char_value  = out_reg.char_value;
    assign tokens.line_status = out_reg.line_status;
    assign tokens.continued   = out_reg.continued;
    assign tokens.last        = out_reg.last;

endmodule
